// File: rtl/core/snev_pkg.sv
`default_nettype none

package snev_pkg;

    // store geometry
    localparam int ELEMENTS  = 16;
    localparam int WORD_BITS = 16;

    // fixed field widths
    localparam int IDX_BITS   = 4;
    localparam int LOAD_BITS  = 16;
    localparam int SHIFT_BITS = 4;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [SHIFT_BITS-1:0] shift_t;

    typedef enum logic
    {
        KIND_LOAD = 1'b0,
        KIND_CMPX = 1'b1
    } kind_t;

    // one input word as held in the input register
    typedef struct packed
    {
        kind_t                kind;
        idx_t                 first_index;
        idx_t                 second_index;
        logic [LOAD_BITS-1:0] load_word;
    } op_t;

    // one result word
    typedef struct packed
    {
        logic did_swap;
        logic array_sorted;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/core/sorting_network_evaluator.sv
// sorting network evaluator: one comparator of a sorting network per word
//
// input channel s_axis: tuser carries the kind (load or compare-exchange),
// tdata carries the two indices and the word to load. a load writes the
// word into the 16-entry store; a compare-exchange swaps the two entries
// when the key of the second is strictly below the key of the first. the
// key drops the low key_shift tag bits, so equal keys keep their order.
// output channel m_axis: one result word per input word, giving whether
// the store is non-decreasing on the full word and whether a swap occurred.
// cfg_wr_en / cfg_wr_data write key_shift; write it only while idle.
// an accepted word waits in the input register until the result register is
// free. throughput: one word per cycle while m_axis_tready is high; the store
// update, the two muxed reads, the key compare and the parallel sortedness
// check all sit between the input register and the result register.
// stall: while m_axis_tready is low the result is held and the input
// register still takes one more word; s_axis_tready then drops.
// reset: store cleared to zeros, key_shift to 0, both registers empty.

`default_nettype none

module sorting_network_evaluator
    import snev_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // first_index, second_index, load_word
    input  wire logic        s_axis_tuser,  // kind

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // array_sorted, did_swap, zero fill

    input  wire logic        cfg_wr_en,
    input  wire shift_t      cfg_wr_data    // key_shift
);

    // input register
    op_t    in_reg;
    logic   in_valid_reg;
    // result register
    res_t   out_reg;
    logic   out_valid_reg;
    // configuration
    shift_t key_shift_reg;

    logic   exec;
    op_t    op_in;
    res_t   res;

    // the held word executes once the result register can take its answer
    assign exec          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || exec;

    always_comb
    begin
        op_in.kind         = kind_t'(s_axis_tuser);
        op_in.first_index  = s_axis_tdata[3:0];
        op_in.second_index = s_axis_tdata[7:4];
        op_in.load_word    = s_axis_tdata[23:8];
    end

    snev_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .exec      (exec),
        .op        (in_reg),
        .key_shift (key_shift_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_shift_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                key_shift_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg <= op_in;
        end
        if (exec)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg.did_swap, out_reg.array_sorted};

endmodule

`default_nettype wire

// File: rtl/core/snev_core.sv
`default_nettype none

module snev_core
    import snev_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   exec,
    input  wire op_t    op,
    input  wire shift_t key_shift,
    output res_t        res
);

    word_t store_reg  [ELEMENTS];
    word_t store_next [ELEMENTS];

    word_t x;
    word_t y;
    word_t key_x;
    word_t key_y;
    logic  first_ok;
    logic  second_ok;
    logic  swapped;
    logic  sorted;

    function automatic word_t key_of(input word_t w, input shift_t sh);
        word_t k;
        if (int'(sh) >= WORD_BITS)
        begin
            k = '0;
        end
        else
        begin
            k = w >> sh;
        end
        return k;
    endfunction

    always_comb
    begin
        first_ok  = int'(op.first_index) < ELEMENTS;
        second_ok = int'(op.second_index) < ELEMENTS;
        x         = store_reg[op.first_index];
        y         = store_reg[op.second_index];
        key_x     = key_of(x, key_shift);
        key_y     = key_of(y, key_shift);
        swapped   = 1'b0;
        for (int i = 0; i < ELEMENTS; i++)
        begin
            store_next[i] = store_reg[i];
        end
        if (exec)
        begin
            unique case (op.kind)
                KIND_LOAD:
                begin
                    if (first_ok)
                    begin
                        store_next[op.first_index] = word_t'(op.load_word);
                    end
                end
                KIND_CMPX:
                begin
                    // strict less keeps equal keys in place
                    if (first_ok && second_ok && (key_y < key_x))
                    begin
                        store_next[op.first_index]  = y;
                        store_next[op.second_index] = x;
                        swapped                     = 1'b1;
                    end
                end
                default:
                begin
                    swapped = 1'b0;
                end
            endcase
        end
    end

    // adjacent pairs of the updated store, all in parallel
    always_comb
    begin
        sorted = 1'b1;
        for (int i = 1; i < ELEMENTS; i++)
        begin
            if (store_next[i] < store_next[i-1])
            begin
                sorted = 1'b0;
            end
        end
        res.array_sorted = sorted;
        res.did_swap     = swapped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ELEMENTS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (exec)
        begin
            for (int i = 0; i < ELEMENTS; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/sorting_network_evaluator_tb.sv
`timescale 1ns / 1ps

module sorting_network_evaluator_tb;
    import snev_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;  // far beyond the slowest correct run
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 110;     // about 1200 input words in all
    localparam int SETTLE       = 4;       // extra wait once every expected result word is back

    // idling modes, one per phase in turn
    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // tracks the word store and key_shift, predicts one result word per input word
    class sort_scoreboard;
        word_t  store [ELEMENTS];
        shift_t key_shift;
        res_t   expected_q [$];
        int     errors;

        function new();
            foreach (store[i])
                store[i] = '0;
            key_shift = '0;
            errors    = 0;
        endfunction

        function void set_key_shift(shift_t value);
            key_shift = value;
        endfunction

        // tag bits below key_shift take no part in the comparison
        function word_t key_of(word_t w);
            if (int'(key_shift) >= WORD_BITS)
                return '0;
            return w >> key_shift;
        endfunction

        function void note_word(kind_t kind, idx_t a, idx_t b, logic [LOAD_BITS-1:0] w);
            res_t  res;
            word_t x;
            word_t y;
            res.did_swap     = 1'b0;
            res.array_sorted = 1'b1;
            if (kind == KIND_LOAD)
            begin
                if (int'(a) < ELEMENTS)
                    store[a] = word_t'(w);
            end
            else if (int'(a) < ELEMENTS && int'(b) < ELEMENTS)
            begin
                x = store[a];
                y = store[b];
                // strict compare keeps equal keys in place
                if (key_of(y) < key_of(x))
                begin
                    store[a]     = y;
                    store[b]     = x;
                    res.did_swap = 1'b1;
                end
            end
            // sortedness is on the full word, tags included
            for (int i = 1; i < ELEMENTS; i++)
                if (store[i] < store[i-1])
                    res.array_sorted = 1'b0;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [7:0] tdata);
            res_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("result word 0x%02h arrived with nothing expected", tdata);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (tdata[0] !== exp_res.array_sorted)
            begin
                $error("array_sorted: expected %0b, got %0b", exp_res.array_sorted, tdata[0]);
                errors++;
            end
            if (tdata[1] !== exp_res.did_swap)
            begin
                $error("did_swap: expected %0b, got %0b", exp_res.did_swap, tdata[1]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // first_index, second_index, load_word
    logic        s_axis_tuser  = 1'b0; // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // array_sorted, did_swap, zero fill
    logic        cfg_wr_en     = 1'b0;
    shift_t      cfg_wr_data   = '0;   // key_shift

    sort_scoreboard sb;
    int unsigned    cycle_count   = 0;
    int unsigned    tx_gap_pct    = 0;
    int unsigned    rx_stall_pct  = 0;
    bit             quiet_stretch = 1'b0;
    int             words_sent;

    sorting_network_evaluator u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorting_network_evaluator_tb failed");
            $finish;
        end
    end

    // receiver: random back-pressure, none during a quiet stretch
    always @(posedge clk)
    begin
        if (quiet_stretch || rx_stall_pct == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end

    // result checking, sampled on the edge that moves the word
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // present one word, hold it until taken, then maybe leave a gap
    task automatic send_word(kind_t kind, idx_t a, idx_t b, logic [LOAD_BITS-1:0] w);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {w, b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_word(kind, a, b, w);
        words_sent++;
        // new quiet stretch decision now and then
        if (words_sent % 40 == 0)
            quiet_stretch = ($urandom_range(3, 0) == 0);
        if (!quiet_stretch && tx_gap_pct != 0 && $urandom_range(99, 0) < tx_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < tx_gap_pct);
        end
    endtask

    // sender holds off until every expected result word is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_key_shift(shift_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_key_shift(value);
    endtask

    // word with a key drawn from a few values, so ties with different tags are common
    function automatic logic [LOAD_BITS-1:0] tied_word(shift_t ks);
        logic [31:0] w;
        if ($urandom_range(2, 0) == 0)
            return LOAD_BITS'($urandom);
        w = ($urandom_range(3, 0) << ks) | ($urandom & ((32'd1 << ks) - 1));
        return LOAD_BITS'(w);
    endfunction

    task automatic send_cmpx(int a, int b);
        send_word(KIND_CMPX, idx_t'(a), idx_t'(b), LOAD_BITS'($urandom));
    endtask

    // fill the whole store, then run a comparator sequence over it
    task automatic network_sequence(shift_t ks);
        int n;
        int a;
        int b;
        for (int i = 0; i < ELEMENTS; i++)
            send_word(KIND_LOAD, idx_t'(i), idx_t'($urandom), tied_word(ks));
        if ($urandom_range(3, 0) == 0)
        begin
            // odd-even transposition network, sorts on key and keeps ties stable
            for (int r = 0; r < ELEMENTS; r++)
                for (int i = r % 2; i + 1 < ELEMENTS; i += 2)
                    send_cmpx(i, i + 1);
        end
        else
        begin
            n = $urandom_range(30, 8);
            for (int k = 0; k < n; k++)
            begin
                a = $urandom_range(ELEMENTS - 1, 0);
                b = $urandom_range(ELEMENTS - 1, 0);
                // mostly ordered comparators, some reversed or degenerate
                if ($urandom_range(4, 0) != 0 && a > b)
                    send_cmpx(b, a);
                else
                    send_cmpx(a, b);
            end
        end
    endtask

    task automatic noise_words();
        int n;
        n = $urandom_range(6, 1);
        for (int k = 0; k < n; k++)
            send_word(kind_t'($urandom_range(1, 0)), idx_t'($urandom), idx_t'($urandom),
                      LOAD_BITS'($urandom));
    endtask

    // corners: zeros and all ones at both ends, same index, reversed comparators
    task automatic directed_words();
        send_cmpx(0, ELEMENTS - 1);
        send_word(KIND_LOAD, 4'd0, 4'hF, 16'hFFFF);
        send_cmpx(0, ELEMENTS - 1);
        send_cmpx(ELEMENTS - 1, ELEMENTS - 1);
        send_cmpx(ELEMENTS - 1, 0);
        send_word(KIND_LOAD, 4'hF, 4'h0, 16'h0000);
        send_cmpx(0, ELEMENTS - 1);
        send_word(KIND_LOAD, 4'd7, 4'hA, 16'h5A5A);
        send_word(KIND_LOAD, 4'd8, 4'h5, 16'hA5A5);
        send_cmpx(8, 7);
        send_cmpx(7, 8);
        send_cmpx(3, 3);
        send_word(KIND_LOAD, 4'd7, 4'hF, 16'h0001);
        send_word(KIND_LOAD, 4'd8, 4'h0, 16'h0001);
        send_cmpx(7, 8);
        for (int i = 0; i < ELEMENTS; i++)
            send_word(KIND_LOAD, idx_t'(i), idx_t'(ELEMENTS - 1 - i), 16'(i * 16'h1000));
    endtask

    initial
    begin
        shift_t     shift_plan [PHASES];
        idle_mode_t mode;
        int         phase_start;
        bit         drained_midway;

        shift_plan = '{4'd0, 4'd15, 4'd4, 4'd1, 4'd8, 4'd2, 4'd12, 4'd0};
        sb         = new();
        words_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            // key_shift only changes while nothing is in flight
            write_key_shift(shift_plan[p]);
            mode = idle_mode_t'(p % 4);
            case (mode)
                IDLE_NONE:     begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                IDLE_SENDER:   begin tx_gap_pct = 85; rx_stall_pct = 0;  end
                IDLE_RECEIVER: begin tx_gap_pct = 0;  rx_stall_pct = 85; end
                default:       begin tx_gap_pct = 27; rx_stall_pct = 27; end
            endcase
            if (p == 0)
                directed_words();
            phase_start    = words_sent;
            drained_midway = 1'b0;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                if ($urandom_range(99, 0) < 65)
                    network_sequence(shift_plan[p]);
                else
                    noise_words();
                // one hold-off in the middle of a busy phase
                if (p == 2 && !drained_midway && words_sent - phase_start > PHASE_WORDS / 2)
                begin
                    drain();
                    drained_midway = 1'b1;
                end
            end
            drain();
        end

        if (sb.errors == 0)
            $display("sorting_network_evaluator_tb passed");
        else
            $display("sorting_network_evaluator_tb failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/snev_pkg.sv
rtl/core/snev_core.sv
rtl/core/sorting_network_evaluator.sv
tb/sv/sorting_network_evaluator_tb.sv
